// File: rtl/tte_pkg.sv
// Shared types, codes and helpers for the tensor-train entry evaluator.
// Used by tte_ctrl, tte_datapath and tensor_train_entry_eval_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

	localparam int DEF_MAX_DIMS = 8;
	localparam int DEF_MAX_RANK = 8;
	localparam int DEF_MAX_MODE = 16;

	localparam int CMD_W  = 2;
	localparam int DIM_W  = 3;
	localparam int RC_W   = 3;
	localparam int MIDX_W = 4;
	localparam int VAL_W  = 32;
	localparam int RVAL_W = 4;
	localparam int ND_W   = 4;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RANK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic core_wr;
		logic capture;
		logic issue;
		logic first;
		logic commit;
		logic emit_ok;
		logic emit_err;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} dp_sts_t;

	function automatic logic [8:0] mode_wrap(input logic [MIDX_W-1:0] m, input int unsigned mm);
		logic [8:0] r;
		logic [8:0] lim;
		r   = {5'b0, m};
		lim = mm[8:0];
		for (int k = 0; k < 8; k++) begin
			if (r >= lim) begin
				r = r - lim;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/tte_ctrl.sv
// Controller: transaction decode, query ordering, rank table and step sequencing.
// Depends on tte_pkg; drives tte_datapath through ctrl_cmd_t and reads dp_sts_t.
`timescale 1ns / 1ps
`default_nettype none

module tte_ctrl #(
	parameter int MAX_DIMS = 8,
	parameter int MAX_RANK = 8,
	parameter int RI_W     = 3,
	parameter int RK_W     = 4
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [tte_pkg::CMD_W-1:0]   command,
	input  wire logic [tte_pkg::DIM_W-1:0]   dim_position,
	input  wire logic [tte_pkg::RVAL_W-1:0]  rank_value,
	input  wire logic                        cfg_wr_en,
	input  wire logic [tte_pkg::ND_W-1:0]    cfg_wr_data,
	output tte_pkg::ctrl_cmd_t               cmd,
	input  wire tte_pkg::dp_sts_t            sts,
	output logic [RI_W-1:0]                  issue_row,
	output logic [RK_W-1:0]                  left_rank,
	output logic [RK_W-1:0]                  right_rank
);

	import tte_pkg::*;

	localparam int RT_W = (MAX_DIMS + 1 > 1) ? $clog2(MAX_DIMS + 1) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [ND_W-1:0]  num_dims_q;
	logic [ND_W-1:0]  expected_q;
	logic [RK_W-1:0]  rank_q [0:MAX_DIMS];
	logic [RI_W-1:0]  cnt_q;
	logic [RK_W-1:0]  left_q;
	logic [RK_W-1:0]  right_q;
	logic             first_q;
	logic [DIM_W-1:0] dim_q;

	logic             accept;
	logic             acc_write;
	logic             acc_rank;
	logic             acc_query;
	logic             q_err;
	logic             q_first;
	logic [ND_W-1:0]  b_left;
	logic [ND_W-1:0]  b_right;
	logic [RK_W-1:0]  left_eff;
	logic [RK_W-1:0]  right_eff;
	logic [RK_W-1:0]  rank_clamped;
	logic             rank_ok;
	logic [ND_W-1:0]  nd_new;
	logic             last_row;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign acc_write = accept && (command == CMD_WRITE);
	assign acc_rank  = accept && (command == CMD_RANK);
	assign acc_query = accept && (command == CMD_QUERY);

	assign b_left  = {1'b0, dim_position};
	assign b_right = b_left + ND_W'(1);
	assign q_err   = (b_left != expected_q) || (int'(dim_position) >= MAX_DIMS);
	assign q_first = (b_left == num_dims_q - ND_W'(1));
	assign rank_ok = (dim_position != '0) && (int'(dim_position) <= MAX_DIMS);

	always_comb begin
		if (b_left == '0 || b_left >= num_dims_q) begin
			left_eff = RK_W'(1);
		end else begin
			left_eff = rank_q[RT_W'(b_left)];
		end
		if (b_right >= num_dims_q) begin
			right_eff = RK_W'(1);
		end else begin
			right_eff = rank_q[RT_W'(b_right)];
		end
	end

	always_comb begin
		if (rank_value == '0) begin
			rank_clamped = RK_W'(1);
		end else if (int'(rank_value) > MAX_RANK) begin
			rank_clamped = RK_W'(MAX_RANK);
		end else begin
			rank_clamped = RK_W'(rank_value);
		end
		if (cfg_wr_data == '0) begin
			nd_new = ND_W'(1);
		end else if (int'(cfg_wr_data) > MAX_DIMS) begin
			nd_new = ND_W'(MAX_DIMS);
		end else begin
			nd_new = cfg_wr_data;
		end
	end

	assign last_row = (cnt_q == RI_W'(left_q - RK_W'(1)));

	always_comb begin
		cmd          = '0;
		cmd.core_wr  = acc_write;
		cmd.capture  = acc_query && !q_err;
		cmd.emit_err = acc_query && q_err;
		cmd.issue    = (state_q == ST_RUN);
		cmd.first    = first_q;
		cmd.commit   = (state_q == ST_DRAIN) && !sts.pipe_busy;
		cmd.emit_ok  = cmd.commit && (dim_q == '0);
	end

	assign issue_row  = cnt_q;
	assign left_rank  = left_q;
	assign right_rank = right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			num_dims_q <= ND_W'(1);
			expected_q <= '0;
			for (int i = 0; i <= MAX_DIMS; i++) begin
				rank_q[i] <= RK_W'(1);
			end
			cnt_q      <= '0;
			left_q     <= RK_W'(1);
			right_q    <= RK_W'(1);
			first_q    <= 1'b0;
			dim_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_rank && rank_ok) begin
						rank_q[RT_W'(b_left)] <= rank_clamped;
					end
					if (acc_query) begin
						if (q_err) begin
							expected_q <= num_dims_q - ND_W'(1);
						end else begin
							left_q  <= left_eff;
							right_q <= right_eff;
							first_q <= q_first;
							dim_q   <= dim_position;
							cnt_q   <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + RI_W'(1);
					if (last_row) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						if (dim_q == '0) begin
							expected_q <= num_dims_q - ND_W'(1);
						end else begin
							expected_q <= {1'b0, dim_q} - ND_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				num_dims_q <= nd_new;
				expected_q <= nd_new - ND_W'(1);
			end
		end
	end

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> busy)
		else $error("row issued while not busy");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !sts.pipe_busy)
		else $error("datapath still busy in idle");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (RK_W'(cnt_q) < left_q))
		else $error("issued row beyond left rank");

endmodule

`default_nettype wire

// File: rtl/tte_datapath.sv
// Datapath: core store lanes, multiplier row, registered adder tree and vectors.
// Depends on tte_pkg; sequenced by tte_ctrl through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tte_datapath #(
	parameter int MAX_DIMS = 8,
	parameter int MAX_RANK = 8,
	parameter int MAX_MODE = 16,
	parameter int RI_W     = 3,
	parameter int RK_W     = 4
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tte_pkg::ctrl_cmd_t               cmd,
	output tte_pkg::dp_sts_t                      sts,
	input  wire logic [RI_W-1:0]                  issue_row,
	input  wire logic [RK_W-1:0]                  left_rank,
	input  wire logic [RK_W-1:0]                  right_rank,
	input  wire logic [tte_pkg::DIM_W-1:0]        dim_position,
	input  wire logic [tte_pkg::RC_W-1:0]         row,
	input  wire logic [tte_pkg::RC_W-1:0]         col,
	input  wire logic [tte_pkg::MIDX_W-1:0]       mode_index,
	input  wire logic signed [tte_pkg::VAL_W-1:0] core_value,
	output logic                                  result_strobe,
	output logic signed [tte_pkg::VAL_W-1:0]      entry_value,
	output logic                                  status
);

	import tte_pkg::*;

	localparam int DEPTH  = MAX_DIMS * MAX_MODE * MAX_RANK;
	localparam int CA_W   = $clog2(DEPTH);
	localparam int MODE_W = $clog2(MAX_MODE);
	localparam int LVLS   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 0;
	localparam int P      = 1 << LVLS;
	localparam int ACC_W  = 64 + LVLS;
	localparam int LAT    = LVLS + 2;
	localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh0001_0000;

	logic [DIM_W-1:0]          dim_q;
	logic [MODE_W-1:0]         mode_q;
	logic signed [VAL_W-1:0]   rd_s1  [0:MAX_RANK-1];
	logic signed [ACC_W-1:0]   node_q [1:2*P-1];
	logic signed [VAL_W-1:0]   vec_q  [0:MAX_RANK-1];
	logic signed [VAL_W-1:0]   nxt_q  [0:MAX_RANK-1];
	logic [LAT-1:0]            pipe_vld_q;
	logic [RI_W-1:0]           pipe_row_q [0:LAT-1];

	logic [MODE_W-1:0]         mode_w;
	logic                      wr_ok;
	logic [CA_W-1:0]           wr_addr;
	logic [CA_W-1:0]           rd_addr;
	logic signed [ACC_W-1:0]   shifted;
	logic                      in_range;
	logic signed [VAL_W-1:0]   wb_val;

	assign mode_w    = MODE_W'(mode_wrap(mode_index, MAX_MODE));
	assign wr_ok     = cmd.core_wr && (int'(dim_position) < MAX_DIMS)
		&& (int'(row) < MAX_RANK) && (int'(col) < MAX_RANK);
	assign wr_addr   = CA_W'((int'(dim_position) * MAX_MODE + int'(mode_w)) * MAX_RANK
		+ int'(row));
	assign rd_addr   = CA_W'((int'(dim_q) * MAX_MODE + int'(mode_q)) * MAX_RANK
		+ int'(issue_row));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			dim_q  <= dim_position;
			mode_q <= mode_w;
		end
	end

	for (genvar j = 0; j < P; j++) begin : g_lane
		if (j < MAX_RANK) begin : g_used
			logic signed [VAL_W-1:0] mem [0:DEPTH-1];
			logic signed [VAL_W-1:0] data_m;
			logic signed [VAL_W-1:0] opnd;
			logic signed [63:0]      prod;

			always_ff @(posedge clk) begin
				if (wr_ok && (int'(col) == j)) begin
					mem[wr_addr] <= core_value;
				end
				if (cmd.issue) begin
					rd_s1[j] <= mem[rd_addr];
				end
			end

			always_comb begin
				data_m = (j < int'(right_rank)) ? rd_s1[j] : '0;
				if (cmd.first) begin
					opnd = (j == 0) ? Q_ONE : '0;
				end else begin
					opnd = vec_q[j];
				end
				prod = data_m * opnd;
			end

			always_ff @(posedge clk) begin
				node_q[P + j] <= ACC_W'(prod);
			end
		end else begin : g_pad
			always_ff @(posedge clk) begin
				node_q[P + j] <= '0;
			end
		end
	end

	for (genvar n = 1; n < P; n++) begin : g_tree
		always_ff @(posedge clk) begin
			node_q[n] <= node_q[2 * n] + node_q[2 * n + 1];
		end
	end

	always_comb begin
		shifted  = node_q[1] >>> 16;
		in_range = (&shifted[ACC_W-1:31]) || !(|shifted[ACC_W-1:31]);
		if (in_range) begin
			wb_val = shifted[VAL_W-1:0];
		end else if (shifted[ACC_W-1]) begin
			wb_val = 32'sh8000_0000;
		end else begin
			wb_val = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_vld_q <= '0;
		end else begin
			pipe_vld_q <= {pipe_vld_q[LAT-2:0], cmd.issue};
		end
	end

	always_ff @(posedge clk) begin
		pipe_row_q[0] <= issue_row;
		for (int k = 1; k < LAT; k++) begin
			pipe_row_q[k] <= pipe_row_q[k-1];
		end
		if (pipe_vld_q[LAT-1]) begin
			nxt_q[pipe_row_q[LAT-1]] <= wb_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_RANK; i++) begin
				vec_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			for (int i = 0; i < MAX_RANK; i++) begin
				vec_q[i] <= (i < int'(left_rank)) ? nxt_q[i] : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit_ok || cmd.emit_err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ok || cmd.emit_err) begin
			entry_value <= cmd.emit_err ? '0 : nxt_q[0];
			status      <= cmd.emit_err;
		end
	end

	assign sts.pipe_busy = |pipe_vld_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && status) |-> (entry_value == '0))
		else $error("error result carries a non-zero value");

	a_wr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.core_wr |-> !(|pipe_vld_q))
		else $error("core write while the pipeline is busy");

	a_commit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !cmd.issue && !(|pipe_vld_q))
		else $error("vector committed before all rows were written back");

endmodule

`default_nettype wire

// File: rtl/tensor_train_entry_eval_top.sv
// Top level of the tensor-train entry evaluator: joins tte_ctrl and tte_datapath.
// Depends on tte_pkg, tte_ctrl and tte_datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-----------------------------------------------
//   input     | start, busy               | command, dim_position, row, col, mode_index,
//             |                           | core_value, rank_value
//   config    | cfg_wr_en                 | cfg_wr_data (num_dims)
//   result    | result_strobe             | entry_value, status
//
// A core write or rank write leaves busy low.
// A valid query transaction holds busy high while its L rows are issued and the pipeline
// drains, where L is the left rank of the queried dimension. One core row is read
// per cycle from the column memories and passes the multiplier row and the adder tree.
// A result appears in the cycle after its final step; an out-of-order query answers in the
// cycle after acceptance with busy low. The receiver cannot stall the block.
// Reset sets the ranks and num_dims to one and clears the ordering state; the core store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tensor_train_entry_eval_top #(
	parameter int MAX_DIMS = tte_pkg::DEF_MAX_DIMS,
	parameter int MAX_RANK = tte_pkg::DEF_MAX_RANK,
	parameter int MAX_MODE = tte_pkg::DEF_MAX_MODE
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [tte_pkg::CMD_W-1:0]        command,
	input  wire logic [tte_pkg::DIM_W-1:0]        dim_position,
	input  wire logic [tte_pkg::RC_W-1:0]         row,
	input  wire logic [tte_pkg::RC_W-1:0]         col,
	input  wire logic [tte_pkg::MIDX_W-1:0]       mode_index,
	input  wire logic signed [tte_pkg::VAL_W-1:0] core_value,
	input  wire logic [tte_pkg::RVAL_W-1:0]       rank_value,
	input  wire logic                             cfg_wr_en,
	input  wire logic [tte_pkg::ND_W-1:0]         cfg_wr_data,
	output logic                                  result_strobe,
	output logic signed [tte_pkg::VAL_W-1:0]      entry_value,
	output logic                                  status
);

	import tte_pkg::*;

	localparam int RI_W = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int RK_W = $clog2(MAX_RANK + 1);

	ctrl_cmd_t       cmd;
	dp_sts_t         sts;
	logic [RI_W-1:0] issue_row;
	logic [RK_W-1:0] left_rank;
	logic [RK_W-1:0] right_rank;

	tte_ctrl #(
		.MAX_DIMS (MAX_DIMS),
		.MAX_RANK (MAX_RANK),
		.RI_W     (RI_W),
		.RK_W     (RK_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.dim_position (dim_position),
		.rank_value   (rank_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.sts          (sts),
		.issue_row    (issue_row),
		.left_rank    (left_rank),
		.right_rank   (right_rank)
	);

	tte_datapath #(
		.MAX_DIMS (MAX_DIMS),
		.MAX_RANK (MAX_RANK),
		.MAX_MODE (MAX_MODE),
		.RI_W     (RI_W),
		.RK_W     (RK_W)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.issue_row     (issue_row),
		.left_rank     (left_rank),
		.right_rank    (right_rank),
		.dim_position  (dim_position),
		.row           (row),
		.col           (col),
		.mode_index    (mode_index),
		.core_value    (core_value),
		.result_strobe (result_strobe),
		.entry_value   (entry_value),
		.status        (status)
	);

endmodule

`default_nettype wire

// File: sim/tb_tensor_train_entry_eval_top.sv
// Self-checking testbench for tensor_train_entry_eval_top: core, rank and query transactions
// are driven from a queue, each entry is predicted in Q16.16 and compared with the result port.
// Depends on tte_pkg and the RTL of the evaluator.
`timescale 1ns / 1ps

module tb_tensor_train_entry_eval_top;
	import tte_pkg::*;

	localparam int DIMS_MAX = DEF_MAX_DIMS;
	localparam int RANK_MAX = DEF_MAX_RANK;
	localparam int MODES = DEF_MAX_MODE;
	localparam int CORE_DEPTH = DIMS_MAX * MODES * RANK_MAX * RANK_MAX;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS = 210;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic ST_OK = 1'b0;
	localparam logic ST_ORDER = 1'b1;
	localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh80000000;

	typedef struct {
		logic [CMD_W-1:0]        command;
		logic [DIM_W-1:0]        dim;
		logic [RC_W-1:0]         row;
		logic [RC_W-1:0]         col;
		logic [MIDX_W-1:0]       mode;
		logic signed [VAL_W-1:0] value;
		logic [RVAL_W-1:0]       rank;
	} tt_txn_t;

	typedef struct {
		logic signed [VAL_W-1:0] entry;
		logic                    status;
	} tt_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [CMD_W-1:0] command = '0;
	logic [DIM_W-1:0] dim_position = '0;
	logic [RC_W-1:0] row = '0;
	logic [RC_W-1:0] col = '0;
	logic [MIDX_W-1:0] mode_index = '0;
	logic signed [VAL_W-1:0] core_value = '0;
	logic [RVAL_W-1:0] rank_value = '0;
	logic cfg_wr_en = 1'b0;
	logic [ND_W-1:0] cfg_wr_data = '0;
	logic result_strobe;
	logic signed [VAL_W-1:0] entry_value;
	logic status;

	tt_txn_t pending_txns[$];
	tt_entry_t expected_entries[$];
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int unsigned error_count = 0;
	int idle_pct = 19;
	logic took = 1'b0;

	// Evaluator state as seen by the checker, updated on each accepted transaction.
	logic signed [VAL_W-1:0] core_mem [CORE_DEPTH];
	int rank_mem [DIMS_MAX+1];
	logic signed [VAL_W-1:0] work_vec [RANK_MAX];
	int eval_dims;
	int next_dim;

	// State of the stimulus side, used to keep every query on written core elements.
	bit core_written [CORE_DEPTH];
	int gen_rank [DIMS_MAX+1];
	int gen_dims;
	int phase_items;

	tensor_train_entry_eval_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.dim_position (dim_position),
		.row          (row),
		.col          (col),
		.mode_index   (mode_index),
		.core_value   (core_value),
		.rank_value   (rank_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_strobe(result_strobe),
		.entry_value  (entry_value),
		.status       (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int core_index(input int d, input int m, input int r, input int c);
		return ((d * MODES + m % MODES) * RANK_MAX + r) * RANK_MAX + c;
	endfunction

	function automatic int clamp_rank(input int v);
		return (v < 1) ? 1 : (v > RANK_MAX) ? RANK_MAX : v;
	endfunction

	function automatic int clamp_dims(input int v);
		return (v < 1) ? 1 : (v > DIMS_MAX) ? DIMS_MAX : v;
	endfunction

	function automatic int boundary_rank(input int nd, input int b, input int stored);
		if (b == 0 || b >= nd) begin
			return 1;
		end
		return stored;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_q16(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return Q_MAX;
		end
		if (v < -64'sd2147483648) begin
			return Q_MIN;
		end
		return v[VAL_W-1:0];
	endfunction

	task automatic predict_txn(input tt_txn_t t);
		int d;
		int m;
		int left;
		int right;
		logic signed [VAL_W-1:0] nxt [RANK_MAX];
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] p;
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		tt_entry_t res;
		d = int'(t.dim);
		m = int'(t.mode);
		case (t.command)
			CMD_WRITE: begin
				core_mem[core_index(d, m, int'(t.row), int'(t.col))] = t.value;
			end
			CMD_RANK: begin
				if (d >= 1) begin
					rank_mem[d] = clamp_rank(int'(t.rank));
				end
			end
			CMD_QUERY: begin
				if (d != next_dim) begin
					res.entry = '0;
					res.status = ST_ORDER;
					expected_entries.push_back(res);
					next_dim = eval_dims - 1;
				end else begin
					left = boundary_rank(eval_dims, d, rank_mem[d]);
					right = boundary_rank(eval_dims, d + 1, rank_mem[d + 1]);
					for (int i = 0; i < RANK_MAX; i++) begin
						nxt[i] = '0;
						if (i < left) begin
							if (d == eval_dims - 1) begin
								nxt[i] = core_mem[core_index(d, m, i, 0)];
							end else begin
								hi = '0;
								lo = '0;
								// Products are split into floor and fraction so the sum cannot overflow.
								for (int j = 0; j < right; j++) begin
									a = core_mem[core_index(d, m, i, j)];
									b = work_vec[j];
									p = a * b;
									hi = hi + (p >>> 16);
									lo = lo + {48'd0, p[15:0]};
								end
								nxt[i] = sat_q16(hi + (lo >>> 16));
							end
						end
					end
					for (int i = 0; i < RANK_MAX; i++) begin
						work_vec[i] = nxt[i];
					end
					if (d == 0) begin
						res.entry = work_vec[0];
						res.status = ST_OK;
						expected_entries.push_back(res);
						next_dim = eval_dims - 1;
					end else begin
						next_dim = d - 1;
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin : check_proc
		tt_txn_t t;
		tt_entry_t want;
		took <= arst_n && start && !busy;
		if (arst_n) begin
			if (cfg_wr_en) begin
				eval_dims = clamp_dims(int'(cfg_wr_data));
				next_dim = eval_dims - 1;
			end
			if (result_strobe) begin
				if (expected_entries.size() == 0) begin
					$error("result_strobe: expected no transaction, got entry_value %0d status %0b",
						entry_value, status);
					error_count++;
				end else begin
					want = expected_entries.pop_front();
					if (entry_value !== want.entry) begin
						$error("entry_value: expected %0d, got %0d", want.entry, entry_value);
						error_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0b, got %0b", want.status, status);
						error_count++;
					end
				end
			end
			if (start && !busy) begin
				t.command = command;
				t.dim = dim_position;
				t.row = row;
				t.col = col;
				t.mode = mode_index;
				t.value = core_value;
				t.rank = rank_value;
				predict_txn(t);
				accepted_count++;
			end
		end
	end

	always @(negedge clk) begin : drive_proc
		tt_txn_t t;
		if (arst_n && (!start || took)) begin
			if (pending_txns.size() != 0 && int'($urandom_range(99)) >= idle_pct) begin
				t = pending_txns.pop_front();
				start <= 1'b1;
				command <= t.command;
				dim_position <= t.dim;
				row <= t.row;
				col <= t.col;
				mode_index <= t.mode;
				core_value <= t.value;
				rank_value <= t.rank;
			end else begin
				start <= 1'b0;
			end
		end
	end

	function automatic logic signed [VAL_W-1:0] rand_q16();
		case ($urandom_range(15))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			3: return '1;
			4, 5: return VAL_W'($urandom);
			default: return VAL_W'($urandom_range(131072)) - 32'sd65536;
		endcase
	endfunction

	function automatic int pick_rank();
		case ($urandom_range(9))
			0: return 0;
			1: return int'($urandom_range(15, 9));
			2: return RANK_MAX;
			default: return int'($urandom_range(4, 1));
		endcase
	endfunction

	function automatic int pick_mode();
		return ($urandom_range(7) == 0) ? int'($urandom_range(15)) : int'($urandom_range(3));
	endfunction

	function automatic tt_txn_t random_txn();
		tt_txn_t t;
		t.command = CMD_SPARE;
		t.dim = DIM_W'($urandom_range(7));
		t.row = RC_W'($urandom_range(7));
		t.col = RC_W'($urandom_range(7));
		t.mode = MIDX_W'($urandom_range(15));
		t.value = rand_q16();
		t.rank = RVAL_W'($urandom_range(15));
		return t;
	endfunction

	task automatic push_txn(input tt_txn_t t);
		pending_txns.push_back(t);
		pushed_count++;
		phase_items++;
		if (t.command == CMD_WRITE) begin
			core_written[core_index(int'(t.dim), int'(t.mode), int'(t.row), int'(t.col))] = 1'b1;
		end else if (t.command == CMD_RANK && t.dim != 0) begin
			gen_rank[int'(t.dim)] = clamp_rank(int'(t.rank));
		end
	endtask

	task automatic push_write(input int d, input int m, input int r, input int c,
			input logic signed [VAL_W-1:0] v);
		tt_txn_t t;
		t = random_txn();
		t.command = CMD_WRITE;
		t.dim = DIM_W'(d);
		t.mode = MIDX_W'(m);
		t.row = RC_W'(r);
		t.col = RC_W'(c);
		t.value = v;
		push_txn(t);
	endtask

	task automatic push_rank(input int d, input int rk);
		tt_txn_t t;
		t = random_txn();
		t.command = CMD_RANK;
		t.dim = DIM_W'(d);
		t.rank = RVAL_W'(rk);
		push_txn(t);
	endtask

	// Any core element that this query could read is written first.
	task automatic push_query(input int d, input int m);
		tt_txn_t t;
		int left;
		int right;
		left = boundary_rank(gen_dims, d, gen_rank[d]);
		right = boundary_rank(gen_dims, d + 1, gen_rank[d + 1]);
		for (int i = 0; i < left; i++) begin
			for (int j = 0; j < right; j++) begin
				if (!core_written[core_index(d, m, i, j)]) begin
					push_write(d, m, i, j, rand_q16());
				end
			end
		end
		t = random_txn();
		t.command = CMD_QUERY;
		t.dim = DIM_W'(d);
		t.mode = MIDX_W'(m);
		push_txn(t);
	endtask

	task automatic push_noise();
		tt_txn_t t;
		t = random_txn();
		case ($urandom_range(3))
			0: push_rank(int'($urandom_range(7)), pick_rank());
			1: begin
				t.command = CMD_WRITE;
				push_txn(t);
			end
			2: push_txn(t);
			default: push_query(int'($urandom_range(7)), pick_mode());
		endcase
	endtask

	task automatic push_sequence();
		int last_dim;
		int kind;
		int bad;
		last_dim = gen_dims - 1;
		kind = int'($urandom_range(99));
		bad = int'($urandom_range(last_dim));
		if (kind < 78) begin
			for (int d = last_dim; d >= 0; d--) begin
				if ($urandom_range(11) == 0) begin
					push_noise();
				end
				push_query(d, pick_mode());
			end
		end else if (kind < 87) begin
			for (int d = last_dim; d >= 0; d--) begin
				push_query((d == bad) ? int'($urandom_range(7)) : d, pick_mode());
			end
		end else if (kind < 94) begin
			for (int d = last_dim; d > bad; d--) begin
				push_query(d, pick_mode());
			end
		end else begin
			repeat ($urandom_range(4, 1)) begin
				push_noise();
			end
		end
	endtask

	task automatic drain();
		while (accepted_count != pushed_count || expected_entries.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input int v);
		drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ND_W'(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		gen_dims = clamp_dims(v);
	endtask

	initial begin : stim_proc
		tt_txn_t t;
		int dims_plan [8];
		int seqs;
		dims_plan = '{8, 0, 15, 5, 9, 2, 1, 3};
		for (int i = 0; i <= DIMS_MAX; i++) begin
			rank_mem[i] = 1;
			gen_rank[i] = 1;
		end
		for (int i = 0; i < RANK_MAX; i++) begin
			work_vec[i] = '0;
		end
		eval_dims = 1;
		next_dim = 0;
		gen_dims = 1;
		phase_items = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single dimension after reset: extreme values and modes, order error, ignored items.
		push_write(0, 15, 0, 0, Q_MAX);
		push_query(0, 15);
		push_write(0, 0, 0, 0, Q_MIN);
		push_query(0, 0);
		push_query(5, 0);
		t.command = CMD_SPARE;
		t.dim = '1;
		t.row = '1;
		t.col = '1;
		t.mode = '1;
		t.value = '1;
		t.rank = '1;
		push_txn(t);
		push_rank(0, 5);
		push_rank(7, 0);

		// Two dimensions: rank saturation, positive overflow, broken order, rank change mid-query.
		write_dims(2);
		push_rank(1, 15);
		push_rank(1, 0);
		push_rank(1, 2);
		push_write(1, 0, 0, 0, Q_MAX);
		push_write(1, 0, 1, 0, Q_MAX);
		push_write(0, 0, 0, 0, Q_MAX);
		push_write(0, 0, 0, 1, Q_MAX);
		push_query(1, 0);
		push_query(0, 0);
		push_query(1, 0);
		push_query(1, 0);
		push_query(0, 0);
		push_query(1, 0);
		push_rank(1, 1);
		push_query(0, 0);

		for (int ph = 0; ph < 8; ph++) begin
			write_dims(dims_plan[ph]);
			idle_pct = (ph < 3) ? 19 : (ph < 6) ? 65 : 0;
			phase_items = 0;
			seqs = 0;
			for (int b = 1; b < gen_dims; b++) begin
				if ($urandom_range(1) == 1) begin
					push_rank(b, pick_rank());
				end
			end
			while (phase_items < PHASE_ITEMS || seqs < 12) begin
				push_sequence();
				seqs++;
			end
		end

		drain();
		if (error_count == 0) begin
			$display("tb_tensor_train_entry_eval_top: clean");
		end else begin
			$display("tb_tensor_train_entry_eval_top: errors");
		end
		$finish;
	end

	initial begin : watchdog_proc
		#8000000;
		$display("tb_tensor_train_entry_eval_top: errors");
		$finish;
	end

endmodule
